// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file dmnr_checker.sv.
// Clock is clk, reset is rst_n (active low) in every user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define AST_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Expression that must never be true outside reset.
`define AST_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);

`endif

// ----- rtl/core/dmnr_pkg.sv -----
// Shared constants and types for the dual Monod nitrifier rate core.
// No dependencies.
package dmnr_pkg;

  localparam int DMNR_DW_DEF = 48;
  localparam int DMNR_F_DEF  = 32;

  // Config bus geometry: eight 64-bit registers at 8-byte stride.
  localparam int APB_DW = 64;
  localparam int APB_AW = 6;

  // Oxygen demand per unit ammonium, 4.57 = K457_NUM / K457_DEN.
  localparam int K457_NUM = 457;
  localparam int K457_DEN = 100;

  // Ghost flag bit within the ghost word.
  localparam logic GHOST_FLAG_BIT = 1'b1;

  typedef enum logic [2:0] {
    REG_KS,
    REG_KO,
    REG_MU,
    REG_YIELD,
    REG_MAINT,
    REG_DECAY,
    REG_RXN_EN,
    REG_GROW_EN
  } reg_idx_t;

  // Start-to-strobe latency of the core.
  function automatic int dmnr_latency(input int dw, input int f);
    return dw + f + 12;
  endfunction

endpackage

// ----- rtl/core/dmnr_mul.sv -----
// Two-stage unsigned multiplier built from four half-width partial products.
// Carries a valid bit and a sideband word alongside. No dependencies.
module dmnr_mul #(
  parameter int AW = 48,
  parameter int BW = 48,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_v,
  input  logic [AW-1:0]        in_a,
  input  logic [BW-1:0]        in_b,
  input  logic [SW-1:0]        in_side,
  output logic                 out_v,
  output logic [AW+BW-1:0]     out_p,
  output logic [SW-1:0]        out_side
);
  localparam int LA = (AW + 1) / 2;
  localparam int HA = AW - LA;
  localparam int LB = (BW + 1) / 2;
  localparam int HB = BW - LB;
  localparam int PW = AW + BW;

  logic [LA+LB-1:0] p00_r, p00_nxt;
  logic [LA+HB-1:0] p01_r, p01_nxt;
  logic [HA+LB-1:0] p10_r, p10_nxt;
  logic [HA+HB-1:0] p11_r, p11_nxt;
  logic [SW-1:0]    side1_r, side2_r;
  logic             v1_r, v2_r;
  logic [PW-1:0]    p_r, p_nxt;

  assign p00_nxt = in_a[LA-1:0]  * in_b[LB-1:0];
  assign p01_nxt = in_a[LA-1:0]  * in_b[BW-1:LB];
  assign p10_nxt = in_a[AW-1:LA] * in_b[LB-1:0];
  assign p11_nxt = in_a[AW-1:LA] * in_b[BW-1:LB];

  assign p_nxt = PW'(p00_r) + (PW'(p01_r) << LB) + (PW'(p10_r) << LA)
               + (PW'(p11_r) << (LA + LB));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    p00_r   <= p00_nxt;
    p01_r   <= p01_nxt;
    p10_r   <= p10_nxt;
    p11_r   <= p11_nxt;
    side1_r <= in_side;
    p_r     <= p_nxt;
    side2_r <= side1_r;
  end

  assign out_v    = v2_r;
  assign out_p    = p_r;
  assign out_side = side2_r;

endmodule

// ----- rtl/core/dmnr_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, QW stages.
// Divisor zero gives quotient zero. No dependencies.
module dmnr_div #(
  parameter int DNW = 49,
  parameter int QW  = 33,
  parameter int SW  = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_v,
  input  logic [DNW-1:0]  in_rem,   // upper dividend bits, below the divisor
  input  logic [QW-1:0]   in_lo,    // dividend bits shifted in, MSB first
  input  logic [DNW-1:0]  in_den,
  input  logic [SW-1:0]   in_side,
  output logic            out_v,
  output logic [QW-1:0]   out_q,
  output logic [SW-1:0]   out_side
);
  logic           v_r    [QW];
  logic [DNW-1:0] rem_r  [QW];
  logic [DNW-1:0] den_r  [QW];
  logic [QW-1:0]  lo_r   [QW];
  logic [QW-1:0]  q_r    [QW];
  logic [SW-1:0]  side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic           v_i;
    logic [DNW-1:0] rem_i;
    logic [DNW-1:0] den_i;
    logic [QW-1:0]  lo_i;
    logic [QW-1:0]  q_i;
    logic [SW-1:0]  side_i;
    logic [DNW:0]   r2;
    logic           take;
    logic [DNW-1:0] rem_nxt;

    if (k == 0) begin : g_first
      assign v_i    = in_v;
      assign rem_i  = in_rem;
      assign den_i  = in_den;
      assign lo_i   = in_lo;
      assign q_i    = '0;
      assign side_i = in_side;
    end else begin : g_next
      assign v_i    = v_r[k-1];
      assign rem_i  = rem_r[k-1];
      assign den_i  = den_r[k-1];
      assign lo_i   = lo_r[k-1];
      assign q_i    = q_r[k-1];
      assign side_i = side_r[k-1];
    end

    assign r2      = {rem_i, lo_i[QW-1-k]};
    assign take    = (den_i != '0) && (r2 >= {1'b0, den_i});
    assign rem_nxt = take ? DNW'(r2 - {1'b0, den_i}) : r2[DNW-1:0];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      rem_r[k]  <= rem_nxt;
      den_r[k]  <= den_i;
      lo_r[k]   <= lo_i;
      q_r[k]    <= q_i | (QW'(take) << (QW - 1 - k));
      side_r[k] <= side_i;
    end
  end

  assign out_v    = v_r[QW-1];
  assign out_q    = q_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

// ----- rtl/core/dual_monod_nitrifier_rates_core.sv -----
// Dual Monod nitrifier rate core: top level.
// Uses dmnr_pkg, dmnr_div and dmnr_mul.
//
// Usage:
//  - Input: one grid cell per word. A word is taken on each clock edge with
//    start high; busy is tied low, so a new cell may enter every cycle.
//  - Output: every cell yields exactly one result word, shown for one cycle
//    with out_strobe high. Results leave in input order.
//  - Throughput: one cell per cycle. The default number format is Q16.32
//    in 48 bits.
//  - Latency is set by the bit-per-stage dividers: the two saturation ratio
//    dividers in parallel (FRAC_BITS+1 stages) and the yield divider
//    (DATA_WIDTH stages), plus four two-stage multipliers in series.
//  - Config: APB-style, 64-bit registers at 8-byte stride, pready tied high.
//    Write only while no cell is in flight.
//  - Reset: synchronous rst_n clears every valid bit and the registers to
//    their defaults (yield 1.0, all else zero). There is no stall path; the
//    receiver must take each result in the cycle it appears.
//  - Assumes FRAC_BITS < DATA_WIDTH.
module dual_monod_nitrifier_rates_core
  import dmnr_pkg::*;
#(
  parameter int DATA_WIDTH = DMNR_DW_DEF,
  parameter int FRAC_BITS  = DMNR_F_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // cell input
  input  logic                         start,
  output logic                         busy,
  input  logic [DATA_WIDTH-1:0]        in_nh4_conc,
  input  logic [DATA_WIDTH-1:0]        in_o2_conc,
  input  logic [DATA_WIDTH-1:0]        in_biomass_density,
  input  logic                         in_ghost_cell,
  input  logic                         in_last_cell,
  // result output
  output logic                         out_strobe,
  output logic signed [DATA_WIDTH-1:0] out_nh4_rate_delta,
  output logic signed [DATA_WIDTH-1:0] out_o2_rate_delta,
  output logic signed [DATA_WIDTH-1:0] out_no2_rate_delta,
  output logic signed [DATA_WIDTH-1:0] out_specific_growth,
  output logic                         out_reaction_valid,
  output logic                         out_growth_valid,
  output logic                         out_sweep_done,
  // config bus
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready
);
  localparam int DW = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int RW = DW + 1;        // ratio divisor width (K + conc)
  localparam int QR = F + 1;         // ratio quotient width, value <= 1.0
  localparam int HW = 2 * DW - F;    // product width after the Q shift

  localparam logic [DW-1:0] HALF = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] MAXP = {1'b0, {(DW-1){1'b1}}};
  localparam logic [63:0] C457_W =
    ((64'(K457_NUM) << F) + 64'(K457_DEN / 2)) / 64'(K457_DEN);
  localparam logic [DW-1:0] C457 = C457_W[DW-1:0];

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  logic [DW-1:0] ks_r, ko_r, mu_r, y_r, mt_r, dc_r;
  logic          rxn_en_r, grow_en_r;
  logic          cfg_wr;
  reg_idx_t      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1:3]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r      <= '0;
      ko_r      <= '0;
      mu_r      <= '0;
      y_r       <= DW'(1) << F;
      mt_r      <= '0;
      dc_r      <= '0;
      rxn_en_r  <= 1'b0;
      grow_en_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_KS:      ks_r      <= pwdata[DW-1:0];
        REG_KO:      ko_r      <= pwdata[DW-1:0];
        REG_MU:      mu_r      <= pwdata[DW-1:0];
        REG_YIELD:   y_r       <= pwdata[DW-1:0];
        REG_MAINT:   mt_r      <= pwdata[DW-1:0];
        REG_DECAY:   dc_r      <= pwdata[DW-1:0];
        REG_RXN_EN:  rxn_en_r  <= pwdata[0];
        REG_GROW_EN: grow_en_r <= pwdata[0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_KS:      prdata = APB_DW'(ks_r);
      REG_KO:      prdata = APB_DW'(ko_r);
      REG_MU:      prdata = APB_DW'(mu_r);
      REG_YIELD:   prdata = APB_DW'(y_r);
      REG_MAINT:   prdata = APB_DW'(mt_r);
      REG_DECAY:   prdata = APB_DW'(dc_r);
      REG_RXN_EN:  prdata = APB_DW'(rxn_en_r);
      REG_GROW_EN: prdata = APB_DW'(grow_en_r);
      default:     prdata = '0;
    endcase
  end

  // O2 stoichiometry factor k = 4.57 - Y as sign and magnitude; registered
  // from the yield register, so it follows it in the next cycle.
  logic [DW-1:0] kmag_r;
  logic          kneg_r;

  always_ff @(posedge clk) begin
    kneg_r <= C457 < y_r;
    kmag_r <= (C457 < y_r) ? (y_r - C457) : (C457 - y_r);
  end

  // ---------------------------------------------------------------------
  // Stage 0: capture the cell, form the saturation divisors
  // ---------------------------------------------------------------------
  logic          v0_r;
  logic [DW-1:0] s0_r, o0_r, x0_r;
  logic          g0_r, l0_r;
  logic [RW-1:0] ds0_r, do0_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s0_r  <= in_nh4_conc;
    o0_r  <= in_o2_conc;
    x0_r  <= in_biomass_density;
    g0_r  <= in_ghost_cell & GHOST_FLAG_BIT;
    l0_r  <= in_last_cell;
    ds0_r <= {1'b0, ks_r} + {1'b0, in_nh4_conc};
    do0_r <= {1'b0, ko_r} + {1'b0, in_o2_conc};
  end

  // ---------------------------------------------------------------------
  // Saturation ratios fS = S/(Ks+S), fO = O/(Ko+O), Q.F, at most 1.0
  // ---------------------------------------------------------------------
  logic          vs1, vo1;
  logic [QR-1:0] fs1, fo1;
  logic [DW-1:0] x1;
  logic          g1, l1;

  dmnr_div #(.DNW(RW), .QW(QR), .SW(DW + 1)) u_div_s (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v0_r),
    .in_rem   ({2'b00, s0_r[DW-1:1]}),
    .in_lo    ({s0_r[0], {F{1'b0}}}),
    .in_den   (ds0_r),
    .in_side  ({x0_r, g0_r}),
    .out_v    (vs1),
    .out_q    (fs1),
    .out_side ({x1, g1})
  );

  dmnr_div #(.DNW(RW), .QW(QR), .SW(1)) u_div_o (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (v0_r),
    .in_rem   ({2'b00, o0_r[DW-1:1]}),
    .in_lo    ({o0_r[0], {F{1'b0}}}),
    .in_den   (do0_r),
    .in_side  (l0_r),
    .out_v    (vo1),
    .out_q    (fo1),
    .out_side (l1)
  );

  // ---------------------------------------------------------------------
  // mu*fS and m*fO
  // ---------------------------------------------------------------------
  logic             m1v, m2v;
  logic [DW+QR-1:0] p1, p2;
  logic [QR-1:0]    fo2;
  logic [DW-1:0]    x2;
  logic             g2, l2;

  dmnr_mul #(.AW(DW), .BW(QR), .SW(QR + DW + 1)) u_mul_mu (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (vs1),
    .in_a     (mu_r),
    .in_b     (fs1),
    .in_side  ({fo1, x1, g1}),
    .out_v    (m1v),
    .out_p    (p1),
    .out_side ({fo2, x2, g2})
  );

  dmnr_mul #(.AW(DW), .BW(QR), .SW(1)) u_mul_mt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (vo1),
    .in_a     (mt_r),
    .in_b     (fo1),
    .in_side  (l1),
    .out_v    (m2v),
    .out_p    (p2),
    .out_side (l2)
  );

  // ---------------------------------------------------------------------
  // tmp1 = (mu*fS)*fO; tmp2 = m*fO rides along
  // ---------------------------------------------------------------------
  logic             m3v;
  logic [DW+QR-1:0] p3;
  logic [DW-1:0]    t2_3, x3;
  logic             g3, l3;

  dmnr_mul #(.AW(DW), .BW(QR), .SW(2 * DW + 2)) u_mul_fo (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (m1v && m2v),
    .in_a     (p1[F +: DW]),
    .in_b     (fo2),
    .in_side  ({p2[F +: DW], x2, g2, l2}),
    .out_v    (m3v),
    .out_p    (p3),
    .out_side ({t2_3, x3, g3, l3})
  );

  // Specific growth tmp1 - tmp2 - b, saturated to signed DW.
  logic [DW-1:0]   tmp1_3;
  logic [DW:0]     loss3;
  logic [DW+1:0]   sgd3;
  logic [DW-1:0]   sg3;

  assign tmp1_3 = p3[F +: DW];
  assign loss3  = {1'b0, t2_3} + {1'b0, dc_r};
  assign sgd3   = {2'b00, tmp1_3} - {1'b0, loss3};

  always_comb begin
    if (sgd3[DW+1:DW-1] == 3'b000 || sgd3[DW+1:DW-1] == 3'b111) begin
      sg3 = sgd3[DW-1:0];
    end else if (sgd3[DW+1]) begin
      sg3 = HALF;
    end else begin
      sg3 = MAXP;
    end
  end

  // ---------------------------------------------------------------------
  // tmp1*X (uptake numerator) and tmp2*X (maintenance h)
  // ---------------------------------------------------------------------
  logic            m4v, m5v;
  logic [2*DW-1:0] p4, p5;
  logic [DW-1:0]   sg4;
  logic            g4, l4;

  dmnr_mul #(.AW(DW), .BW(DW), .SW(DW + 1)) u_mul_x1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (m3v),
    .in_a     (tmp1_3),
    .in_b     (x3),
    .in_side  ({sg3, g3}),
    .out_v    (m4v),
    .out_p    (p4),
    .out_side ({sg4, g4})
  );

  dmnr_mul #(.AW(DW), .BW(DW), .SW(1)) u_mul_x2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (m3v),
    .in_a     (t2_3),
    .in_b     (x3),
    .in_side  (l3),
    .out_v    (m5v),
    .out_p    (p5),
    .out_side (l4)
  );

  // ---------------------------------------------------------------------
  // g = tmp1*X / Y. Quotient >= 2^DW is flagged up front and capped.
  // ---------------------------------------------------------------------
  logic          ovf4;
  logic          gv;
  logic [DW-1:0] gq;
  logic          ovf5, g5, l5;
  logic [DW-1:0] sg5;
  logic [HW-1:0] h5;
  logic [DW-1:0] gc5;

  assign ovf4 = (y_r != '0) && (p4[2*DW-1:DW] >= y_r);

  dmnr_div #(.DNW(DW), .QW(DW), .SW(DW + HW + 3)) u_div_y (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (m4v && m5v),
    .in_rem   (p4[2*DW-1:DW]),
    .in_lo    (p4[DW-1:0]),
    .in_den   (y_r),
    .in_side  ({ovf4, sg4, g4, p5[F +: HW], l4}),
    .out_v    (gv),
    .out_q    (gq),
    .out_side ({ovf5, sg5, g5, h5, l5})
  );

  assign gc5 = (ovf5 || gq > HALF) ? HALF : gq;

  // ---------------------------------------------------------------------
  // q = |k| * gc
  // ---------------------------------------------------------------------
  logic            m6v;
  logic [2*DW-1:0] p6;
  logic [DW-1:0]   gc6, sg6;
  logic [HW-1:0]   h6, q6;
  logic            g6, l6;

  dmnr_mul #(.AW(DW), .BW(DW), .SW(2 * DW + HW + 2)) u_mul_k (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_v     (gv),
    .in_a     (kmag_r),
    .in_b     (gc5),
    .in_side  ({gc5, h5, sg5, g5, l5}),
    .out_v    (m6v),
    .out_p    (p6),
    .out_side ({gc6, h6, sg6, g6, l6})
  );

  assign q6 = p6[F +: HW];

  // ---------------------------------------------------------------------
  // O2 magnitude and sign: -(k*gc + h)
  // ---------------------------------------------------------------------
  logic          f7v_r;
  logic [HW:0]   mag7_r, mag_nxt;
  logic          neg7_r, neg_nxt;
  logic [DW-1:0] gc7_r, sg7_r;
  logic          g7_r, l7_r;

  always_comb begin
    if (!kneg_r) begin
      mag_nxt = {1'b0, q6} + {1'b0, h6};
      neg_nxt = 1'b1;
    end else if (h6 >= q6) begin
      mag_nxt = {1'b0, h6 - q6};
      neg_nxt = 1'b1;
    end else begin
      mag_nxt = {1'b0, q6 - h6};
      neg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f7v_r <= 1'b0;
    end else begin
      f7v_r <= m6v;
    end
  end

  always_ff @(posedge clk) begin
    mag7_r <= mag_nxt;
    neg7_r <= neg_nxt;
    gc7_r  <= gc6;
    sg7_r  <= sg6;
    g7_r   <= g6;
    l7_r   <= l6;
  end

  // ---------------------------------------------------------------------
  // Output register: saturate, gate by the enables and the ghost flag
  // ---------------------------------------------------------------------
  logic          reac7, grow7;
  logic [DW-1:0] o2_7, nh4_7, no2_7;
  logic          out_strobe_r;
  logic [DW-1:0] nh4_r, o2_r, no2_r, sg_r;
  logic          rv_r, gvld_r, done_r;

  assign reac7 = rxn_en_r && !g7_r;
  assign grow7 = grow_en_r;
  assign nh4_7 = {DW{1'b0}} - gc7_r;
  assign no2_7 = (gc7_r == HALF) ? MAXP : gc7_r;

  always_comb begin
    if (neg7_r) begin
      o2_7 = (mag7_r > (HW+1)'(HALF)) ? HALF : ({DW{1'b0}} - mag7_r[DW-1:0]);
    end else begin
      o2_7 = (mag7_r > (HW+1)'(MAXP)) ? MAXP : mag7_r[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= f7v_r;
    end
  end

  always_ff @(posedge clk) begin
    nh4_r  <= reac7 ? nh4_7 : '0;
    o2_r   <= reac7 ? o2_7  : '0;
    no2_r  <= reac7 ? no2_7 : '0;
    sg_r   <= grow7 ? sg7_r : '0;
    rv_r   <= reac7;
    gvld_r <= grow7;
    done_r <= l7_r;
  end

  assign out_strobe          = out_strobe_r;
  assign out_nh4_rate_delta  = nh4_r;
  assign out_o2_rate_delta   = o2_r;
  assign out_no2_rate_delta  = no2_r;
  assign out_specific_growth = sg_r;
  assign out_reaction_valid  = rv_r;
  assign out_growth_valid    = gvld_r;
  assign out_sweep_done      = done_r;

endmodule

// ----- rtl/core/dmnr_checker.sv -----
// Port-level checker for the nitrifier rate core, bound to the top level.
// Uses dmnr_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dmnr_checker
  import dmnr_pkg::*;
#(
  parameter int DATA_WIDTH = DMNR_DW_DEF,
  parameter int FRAC_BITS  = DMNR_F_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         out_strobe,
  input logic signed [DATA_WIDTH-1:0] out_nh4_rate_delta,
  input logic signed [DATA_WIDTH-1:0] out_o2_rate_delta,
  input logic signed [DATA_WIDTH-1:0] out_no2_rate_delta,
  input logic signed [DATA_WIDTH-1:0] out_specific_growth,
  input logic                         out_reaction_valid,
  input logic                         out_growth_valid
);
  localparam int LAT = dmnr_latency(DATA_WIDTH, FRAC_BITS);
  localparam logic [DATA_WIDTH-1:0] MAXP = {1'b0, {(DATA_WIDTH-1){1'b1}}};

  `AST_NEVER(a_never_busy, busy, "core raised busy")

  `AST_IMPL(a_strobe_has_start, out_strobe, $past(start, LAT), "result without a cell")

  `AST_IMPL(a_rxn_off_zero, out_strobe && !out_reaction_valid, out_nh4_rate_delta == '0 && out_o2_rate_delta == '0 && out_no2_rate_delta == '0, "deltas nonzero with reaction off")

  `AST_IMPL(a_nh4_no2_mirror, out_strobe && out_reaction_valid, DATA_WIDTH'(out_nh4_rate_delta + out_no2_rate_delta) == '0 || out_no2_rate_delta == MAXP, "nh4 and no2 deltas disagree")

  `AST_IMPL(a_grow_off_zero, out_strobe && !out_growth_valid, out_specific_growth == '0, "growth nonzero with growth off")

endmodule

bind dual_monod_nitrifier_rates_core dmnr_checker #(
  .DATA_WIDTH (DATA_WIDTH),
  .FRAC_BITS  (FRAC_BITS)
) u_dmnr_checker (.*);
